### rtl/core/sdspi_pkg.sv
// ----------------------------------------------------------------------------
// sdspi_pkg
// types, codes and helpers shared by the sd spi host sequencer
// ----------------------------------------------------------------------------
package sdspi_pkg;

    localparam int BLOCK_BYTES = 512;
    localparam int BLK_AW      = $clog2(BLOCK_BYTES);
    localparam int WSTREAM_LAST = BLOCK_BYTES + 6;

    localparam logic [2:0] REQ_INIT  = 3'd0;
    localparam logic [2:0] REQ_READ  = 3'd1;
    localparam logic [2:0] REQ_WRITE = 3'd2;
    localparam logic [2:0] REQ_LOAD  = 3'd3;
    localparam logic [2:0] REQ_RX    = 3'd4;
    localparam logic [2:0] REQ_TICK  = 3'd5;

    localparam logic [2:0] CFG_READY_TO  = 3'd0;
    localparam logic [2:0] CFG_PWR_DLY   = 3'd1;
    localparam logic [2:0] CFG_IDLE_LIM  = 3'd2;
    localparam logic [2:0] CFG_RESP_LIM  = 3'd3;
    localparam logic [2:0] CFG_RETRY_LIM = 3'd4;
    localparam logic [2:0] CFG_TOKEN_LIM = 3'd5;
    localparam logic [2:0] CFG_BUSY_LIM  = 3'd6;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_READY_TO = 3'd1;
    localparam logic [2:0] ST_NO_RESP  = 3'd2;
    localparam logic [2:0] ST_RETRY    = 3'd3;
    localparam logic [2:0] ST_TOKEN_TO = 3'd4;
    localparam logic [2:0] ST_WR_REJ   = 3'd5;
    localparam logic [2:0] ST_BUSY_TO  = 3'd6;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] sector;
        logic [7:0]  rx_byte;
        logic [7:0]  data_byte;
        logic [8:0]  data_index;
    } sdspi_in_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       chip_select;
        logic       fast_clock;
        logic [7:0] read_byte;
        logic       read_valid;
        logic [8:0] read_index;
        logic       done_res;
        logic [2:0] status;
        logic [1:0] card_type;
        logic       last;
    } sdspi_out_t;

    typedef struct packed {
        logic [9:0]  ready_timeout_ms;
        logic [9:0]  power_delay_ms;
        logic [15:0] idle_poll_limit;
        logic [7:0]  response_poll_limit;
        logic [8:0]  init_retry_limit;
        logic [15:0] token_poll_limit;
        logic [15:0] busy_poll_limit;
    } sdspi_cfg_t;

    // buffer read request from sequencer to buffer
    typedef struct packed {
        logic              en;
        logic [BLK_AW-1:0] addr;
    } sdspi_brd_t;

endpackage

### rtl/core/sdspi_buf.sv
// ----------------------------------------------------------------------------
// sdspi_buf
// block buffer: one write port, one registered read port
// ----------------------------------------------------------------------------
module sdspi_buf (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [sdspi_pkg::BLK_AW-1:0] waddr,
    input  logic [7:0]                 wdata,
    input  sdspi_pkg::sdspi_brd_t      rd,
    output logic [7:0]                 rdata
);
    import sdspi_pkg::*;

    logic [7:0] mem [BLOCK_BYTES];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rdata <= mem[rd.addr];
        end
    end
endmodule

### rtl/core/sdspi_cfg.sv
// ----------------------------------------------------------------------------
// sdspi_cfg
// configuration register file
// ----------------------------------------------------------------------------
module sdspi_cfg (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [2:0]            wr_index,
    input  logic [31:0]           wr_data,
    output sdspi_pkg::sdspi_cfg_t cfg
);
    import sdspi_pkg::*;

    sdspi_cfg_t cfg_reg;
    assign cfg = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ready_timeout_ms    <= 10'd500;
            cfg_reg.power_delay_ms      <= 10'd100;
            cfg_reg.idle_poll_limit     <= 16'h1fff;
            cfg_reg.response_poll_limit <= 8'd200;
            cfg_reg.init_retry_limit    <= 9'd400;
            cfg_reg.token_poll_limit    <= 16'h0fff;
            cfg_reg.busy_poll_limit     <= 16'hfffe;
        end else if (wr_en) begin
            unique case (wr_index)
                CFG_READY_TO:  cfg_reg.ready_timeout_ms    <= wr_data[9:0];
                CFG_PWR_DLY:   cfg_reg.power_delay_ms      <= wr_data[9:0];
                CFG_IDLE_LIM:  cfg_reg.idle_poll_limit     <= wr_data[15:0];
                CFG_RESP_LIM:  cfg_reg.response_poll_limit <= wr_data[7:0];
                CFG_RETRY_LIM: cfg_reg.init_retry_limit    <= wr_data[8:0];
                CFG_TOKEN_LIM: cfg_reg.token_poll_limit    <= wr_data[15:0];
                CFG_BUSY_LIM:  cfg_reg.busy_poll_limit     <= wr_data[15:0];
                default: ;
            endcase
        end
    end
endmodule

### rtl/core/sdspi_seq.sv
// ----------------------------------------------------------------------------
// sdspi_seq
// protocol sequencer: one beat per cycle while in_ready is high, result into a two-entry output queue
// ----------------------------------------------------------------------------
module sdspi_seq (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  sdspi_pkg::sdspi_in_t   in_data,
    input  sdspi_pkg::sdspi_cfg_t  cfg,
    output sdspi_pkg::sdspi_brd_t  brd,
    input  logic [7:0]             bdata,
    output logic                   out_valid,
    input  logic                   out_ready,
    output sdspi_pkg::sdspi_out_t  out_data,
    output logic                   busy
);
    import sdspi_pkg::*;

    localparam logic [4:0] PH_IDLE = 5'd0, PH_PWR = 5'd1, PH_DUMMY10 = 5'd2,
        PH_PON_CMD0 = 5'd3, PH_PON_DUMP = 5'd4, PH_CMD0 = 5'd5, PH_CMD8 = 5'd6,
        PH_V1_DUMP = 5'd7, PH_V1_55 = 5'd8, PH_V1_41 = 5'd9, PH_V1_FAST = 5'd10,
        PH_CMD59 = 5'd11, PH_CMD16 = 5'd12, PH_V2_OCR8 = 5'd13, PH_V2_DUMP = 5'd14,
        PH_V2_55 = 5'd15, PH_V2_41 = 5'd16, PH_CMD58 = 5'd17, PH_V2_OCR58 = 5'd18,
        PH_FINAL = 5'd19, PH_CMD17 = 5'd20, PH_RD_GAP = 5'd21, PH_RD_END = 5'd22,
        PH_CMD24 = 5'd23, PH_WR_GAP = 5'd24, PH_WR_END = 5'd25;

    localparam logic [3:0] SB_NONE = 4'd0, SB_WAIT_MS = 4'd1, SB_DUMMY = 4'd2,
        SB_READY = 4'd3, SB_SEND = 4'd4, SB_RESP = 4'd5, SB_IDLE_RESP = 4'd6,
        SB_OCR = 4'd7, SB_TOKEN = 4'd8, SB_DATA = 4'd9, SB_CRC = 4'd10,
        SB_WSTREAM = 4'd11, SB_BUSY = 4'd12;

    logic [4:0]  phase_reg, phase_next;
    logic [3:0]  sub_reg, sub_next;
    logic [1:0]  kind_reg, kind_next;
    logic [2:0]  pend_reg, pend_next;
    logic [15:0] poll_reg, poll_next;
    logic [8:0]  retry_reg, retry_next;
    logic [9:0]  ms_reg, ms_next;
    logic [9:0]  pos_reg, pos_next;
    logic [47:0] frame_reg, frame_next;
    logic        cs_reg, cs_next;
    logic        fast_reg, fast_next;

    // buffer byte pending: emitted result waits for the read data in the next cycle
    logic        wpend_reg, wpend_next;

    // result produced this cycle
    logic        emit;
    sdspi_out_t  res;
    logic        use_buf;

    // two-entry output queue
    sdspi_out_t  q_reg [2];
    logic [1:0]  q_cnt_reg;
    logic        qhead_reg;

    logic        take, push, pop;
    sdspi_out_t  push_data;
    logic [2:0]  req;
    logic [7:0]  rx;
    logic [31:0] addr;

    assign req  = in_data.req_type;
    assign rx   = in_data.rx_byte;
    assign addr = (kind_reg == 2'd3) ? in_data.sector : {in_data.sector[22:0], 9'd0};

    // a buffered write byte lands in the next cycle, so input holds meanwhile
    assign in_ready = !wpend_reg && (q_cnt_reg != 2'd2);
    assign take     = in_valid && in_ready;
    assign busy     = (phase_reg != PH_IDLE) || wpend_reg || (q_cnt_reg != 2'd0);

    function automatic logic [7:0] fbyte(input logic [47:0] f, input logic [9:0] p);
        logic [7:0] b;
        unique case (p[2:0])
            3'd0: b = f[47:40];
            3'd1: b = f[39:32];
            3'd2: b = f[31:24];
            3'd3: b = f[23:16];
            3'd4: b = f[15:8];
            default: b = f[7:0];
        endcase
        return b;
    endfunction

    always_comb begin
        phase_next = phase_reg; sub_next = sub_reg; kind_next = kind_reg;
        pend_next = pend_reg; poll_next = poll_reg; retry_next = retry_reg;
        ms_next = ms_reg; pos_next = pos_reg; frame_next = frame_reg;
        cs_next = cs_reg; fast_next = fast_reg;
        emit = 1'b0; use_buf = 1'b0;
        res = '0;
        brd.en = 1'b0;
        brd.addr = '0;

        if (take) begin
            priority case (1'b1)
                (req == REQ_INIT): begin
                    if (phase_reg == PH_IDLE) begin
                        kind_next = 2'd0; cs_next = 1'b1; fast_next = 1'b0; ms_next = '0;
                        if (cfg.power_delay_ms == 10'd0) begin
                            phase_next = PH_DUMMY10; sub_next = SB_DUMMY; pos_next = 10'd10;
                            emit = 1'b1; res.tx_byte = 8'hff;
                        end else begin
                            phase_next = PH_PWR; sub_next = SB_WAIT_MS;
                        end
                    end
                end
                (req == REQ_READ || req == REQ_WRITE): begin
                    if (phase_reg == PH_IDLE) begin
                        cs_next = 1'b0;
                        phase_next = (req == REQ_READ) ? PH_CMD17 : PH_CMD24;
                        frame_next = {(req == REQ_READ) ? 8'h51 : 8'h58, addr, 8'h00};
                        sub_next = SB_READY; ms_next = '0;
                        emit = 1'b1; res.tx_byte = 8'hff;
                    end
                end
                (req == REQ_TICK): begin
                    if (sub_reg == SB_WAIT_MS || sub_reg == SB_READY) begin
                        if (ms_reg != 10'd1023) ms_next = ms_reg + 10'd1;
                        if (sub_reg == SB_WAIT_MS && ms_next >= cfg.power_delay_ms) begin
                            phase_next = PH_DUMMY10; sub_next = SB_DUMMY; pos_next = 10'd10;
                            emit = 1'b1; res.tx_byte = 8'hff;
                        end
                    end
                end
                (req == REQ_RX && phase_reg != PH_IDLE): begin
                    // default next action helpers are written out per case
                    unique case (sub_reg)
                        SB_DUMMY: begin
                            logic [9:0] np;
                            np = (pos_reg != 10'd0) ? pos_reg - 10'd1 : 10'd0;
                            pos_next = np;
                            emit = 1'b1;
                            if (np != 10'd0) begin
                                res.tx_byte = 8'hff;
                            end else begin
                                unique case (phase_reg)
                                    PH_DUMMY10: begin
                                        cs_next = 1'b0; phase_next = PH_PON_CMD0;
                                        frame_next = {8'h40, 32'd0, 8'h95};
                                        sub_next = SB_SEND; pos_next = '0;
                                        res.tx_byte = 8'h40;
                                    end
                                    PH_PON_DUMP: begin
                                        if (pend_reg != ST_OK) begin
                                            phase_next = PH_IDLE; sub_next = SB_NONE;
                                            res.done_res = 1'b1; res.status = pend_reg;
                                        end else begin
                                            cs_next = 1'b0; phase_next = PH_CMD0;
                                            frame_next = {8'h40, 32'd0, 8'h95};
                                            sub_next = SB_READY; ms_next = '0;
                                            res.tx_byte = 8'hff;
                                        end
                                    end
                                    PH_V1_DUMP, PH_V2_DUMP: begin
                                        retry_next = '0; cs_next = 1'b0;
                                        phase_next = (phase_reg == PH_V1_DUMP) ? PH_V1_55
                                                                               : PH_V2_55;
                                        frame_next = {8'h77, 40'd0};
                                        sub_next = SB_READY; ms_next = '0;
                                        res.tx_byte = 8'hff;
                                    end
                                    PH_V1_FAST: begin
                                        phase_next = PH_CMD59;
                                        frame_next = {8'h7b, 32'd0, 8'h95};
                                        sub_next = SB_READY; ms_next = '0;
                                        res.tx_byte = 8'hff;
                                    end
                                    PH_RD_GAP, PH_WR_GAP: begin
                                        cs_next = 1'b0;
                                        sub_next = (phase_reg == PH_RD_GAP) ? SB_TOKEN
                                                                            : SB_WSTREAM;
                                        pos_next = '0; poll_next = '0;
                                        res.tx_byte = 8'hff;
                                    end
                                    default: begin
                                        if (phase_reg == PH_FINAL) fast_next = 1'b1;
                                        phase_next = PH_IDLE; sub_next = SB_NONE;
                                        res.done_res = 1'b1;
                                    end
                                endcase
                            end
                        end
                        SB_READY: begin
                            emit = 1'b1;
                            if (rx == 8'hff) begin
                                sub_next = SB_SEND; pos_next = '0;
                                res.tx_byte = frame_reg[47:40];
                            end else if (ms_reg >= cfg.ready_timeout_ms) begin
                                cs_next = 1'b1; phase_next = PH_IDLE; sub_next = SB_NONE;
                                res.done_res = 1'b1; res.status = ST_READY_TO;
                            end else begin
                                res.tx_byte = 8'hff;
                            end
                        end
                        SB_SEND: begin
                            emit = 1'b1;
                            pos_next = pos_reg + 10'd1;
                            if (pos_next < 10'd6) begin
                                res.tx_byte = fbyte(frame_reg, pos_next);
                            end else begin
                                sub_next = (phase_reg == PH_PON_CMD0) ? SB_IDLE_RESP : SB_RESP;
                                poll_next = '0;
                                res.tx_byte = 8'hff;
                            end
                        end
                        SB_RESP: begin
                            emit = 1'b1;
                            if (rx != 8'hff) begin
                                // command answered
                                unique case (phase_reg)
                                    PH_CMD0: begin
                                        if (rx == 8'h01) begin
                                            phase_next = PH_CMD8;
                                            frame_next = {8'h48, 32'h1aa, 8'h87};
                                            sub_next = SB_READY; ms_next = '0;
                                            res.tx_byte = 8'hff;
                                        end else begin
                                            cs_next = 1'b1; phase_next = PH_IDLE;
                                            sub_next = SB_NONE;
                                            res.done_res = 1'b1; res.status = ST_NO_RESP;
                                        end
                                    end
                                    PH_CMD8: begin
                                        res.tx_byte = 8'hff;
                                        if (rx == 8'h05) begin
                                            kind_next = 2'd1; cs_next = 1'b1;
                                            phase_next = PH_V1_DUMP; sub_next = SB_DUMMY;
                                            pos_next = 10'd1;
                                        end else if (rx == 8'h01) begin
                                            phase_next = PH_V2_OCR8; sub_next = SB_OCR;
                                            pos_next = '0; poll_next = '0;
                                        end else begin
                                            cs_next = 1'b1; phase_next = PH_FINAL;
                                            sub_next = SB_DUMMY; pos_next = 10'd1;
                                        end
                                    end
                                    PH_V1_55, PH_V2_55: begin
                                        phase_next = (phase_reg == PH_V1_55) ? PH_V1_41
                                                                             : PH_V2_41;
                                        frame_next = (phase_reg == PH_V1_55)
                                            ? {8'h69, 40'd0}
                                            : {8'h69, 32'h40000000, 8'h00};
                                        sub_next = SB_READY; ms_next = '0;
                                        res.tx_byte = 8'hff;
                                    end
                                    PH_V1_41, PH_V2_41: begin
                                        if (retry_reg != 9'd511) retry_next = retry_reg + 9'd1;
                                        if (rx == 8'h00) begin
                                            res.tx_byte = 8'hff;
                                            if (phase_reg == PH_V1_41) begin
                                                fast_next = 1'b1; phase_next = PH_V1_FAST;
                                                sub_next = SB_DUMMY; pos_next = 10'd1;
                                            end else begin
                                                phase_next = PH_CMD58;
                                                frame_next = {8'h7a, 40'd0};
                                                sub_next = SB_READY; ms_next = '0;
                                            end
                                        end else if (retry_next >= cfg.init_retry_limit) begin
                                            cs_next = 1'b1; phase_next = PH_IDLE;
                                            sub_next = SB_NONE;
                                            res.done_res = 1'b1; res.status = ST_RETRY;
                                        end else begin
                                            phase_next = (phase_reg == PH_V1_41) ? PH_V1_55
                                                                                 : PH_V2_55;
                                            frame_next = {8'h77, 40'd0};
                                            sub_next = SB_READY; ms_next = '0;
                                            res.tx_byte = 8'hff;
                                        end
                                    end
                                    PH_CMD59: begin
                                        phase_next = PH_CMD16;
                                        frame_next = {8'h50, 32'd512, 8'h95};
                                        sub_next = SB_READY; ms_next = '0;
                                        res.tx_byte = 8'hff;
                                    end
                                    PH_CMD16: begin
                                        cs_next = 1'b1; phase_next = PH_FINAL;
                                        sub_next = SB_DUMMY; pos_next = 10'd1;
                                        res.tx_byte = 8'hff;
                                    end
                                    PH_CMD58, PH_CMD17, PH_CMD24: begin
                                        if (rx != 8'h00) begin
                                            cs_next = 1'b1; phase_next = PH_IDLE;
                                            sub_next = SB_NONE;
                                            res.done_res = 1'b1; res.status = ST_NO_RESP;
                                        end else begin
                                            res.tx_byte = 8'hff;
                                            pos_next = '0;
                                            if (phase_reg == PH_CMD58) begin
                                                phase_next = PH_V2_OCR58; sub_next = SB_OCR;
                                                poll_next = '0;
                                            end else begin
                                                cs_next = 1'b1; sub_next = SB_DUMMY;
                                                pos_next = 10'd1;
                                                phase_next = (phase_reg == PH_CMD17)
                                                    ? PH_RD_GAP : PH_WR_GAP;
                                            end
                                        end
                                    end
                                    default: begin
                                        cs_next = 1'b1; phase_next = PH_IDLE;
                                        sub_next = SB_NONE;
                                        res.done_res = 1'b1; res.status = ST_NO_RESP;
                                    end
                                endcase
                            end else if ({8'd0, poll_reg} > {8'd0, 8'd0, cfg.response_poll_limit}) begin
                                cs_next = 1'b1; phase_next = PH_IDLE; sub_next = SB_NONE;
                                res.done_res = 1'b1; res.status = ST_NO_RESP;
                            end else begin
                                poll_next = poll_reg + 16'd1;
                                res.tx_byte = 8'hff;
                            end
                        end
                        SB_IDLE_RESP: begin
                            emit = 1'b1; res.tx_byte = 8'hff;
                            if (rx == 8'h01 || poll_reg >= cfg.idle_poll_limit) begin
                                pend_next = (rx == 8'h01) ? ST_OK : ST_NO_RESP;
                                cs_next = 1'b1; phase_next = PH_PON_DUMP;
                                sub_next = SB_DUMMY; pos_next = 10'd1;
                            end else begin
                                poll_next = poll_reg + 16'd1;
                            end
                        end
                        SB_OCR: begin
                            emit = 1'b1; res.tx_byte = 8'hff;
                            if (phase_reg == PH_V2_OCR58 && pos_reg == 10'd0)
                                kind_next = rx[6] ? 2'd3 : 2'd2;
                            pos_next = pos_reg + 10'd1;
                            if (pos_next >= 10'd4) begin
                                cs_next = 1'b1; sub_next = SB_DUMMY; pos_next = 10'd1;
                                phase_next = (phase_reg == PH_V2_OCR8) ? PH_V2_DUMP
                                                                       : PH_FINAL;
                            end
                        end
                        SB_TOKEN: begin
                            emit = 1'b1;
                            if (rx == 8'hfe) begin
                                sub_next = SB_DATA; pos_next = '0; res.tx_byte = 8'hff;
                            end else if (poll_reg >= cfg.token_poll_limit) begin
                                cs_next = 1'b1; phase_next = PH_IDLE; sub_next = SB_NONE;
                                res.done_res = 1'b1; res.status = ST_TOKEN_TO;
                            end else begin
                                poll_next = poll_reg + 16'd1; res.tx_byte = 8'hff;
                            end
                        end
                        SB_DATA: begin
                            emit = 1'b1; res.tx_byte = 8'hff;
                            res.read_byte = rx; res.read_valid = 1'b1;
                            res.read_index = pos_reg[BLK_AW-1:0];
                            pos_next = pos_reg + 10'd1;
                            if (pos_next >= 10'(BLOCK_BYTES)) begin
                                sub_next = SB_CRC; pos_next = '0;
                            end
                        end
                        SB_CRC: begin
                            emit = 1'b1; res.tx_byte = 8'hff;
                            pos_next = pos_reg + 10'd1;
                            if (pos_next >= 10'd2) begin
                                cs_next = 1'b1; phase_next = PH_RD_END;
                                sub_next = SB_DUMMY; pos_next = 10'd1;
                            end
                        end
                        SB_WSTREAM: begin
                            emit = 1'b1;
                            if ({1'b0, pos_reg} >= 11'(WSTREAM_LAST)) begin
                                if (rx[4:0] != 5'h05) begin
                                    cs_next = 1'b1; phase_next = PH_IDLE; sub_next = SB_NONE;
                                    res.done_res = 1'b1; res.status = ST_WR_REJ;
                                end else begin
                                    sub_next = SB_BUSY; poll_next = '0; res.tx_byte = 8'hff;
                                end
                            end else begin
                                pos_next = pos_reg + 10'd1;
                                if (pos_next < 10'd3 || pos_next >= 10'(BLOCK_BYTES + 4)) begin
                                    res.tx_byte = 8'hff;
                                end else if (pos_next == 10'd3) begin
                                    res.tx_byte = 8'hfe;
                                end else begin
                                    // data byte comes from the buffer in the next cycle
                                    use_buf = 1'b1;
                                    brd.en = 1'b1;
                                    brd.addr = BLK_AW'(pos_next - 10'd4);
                                end
                            end
                        end
                        SB_BUSY: begin
                            emit = 1'b1;
                            if (rx != 8'h00) begin
                                cs_next = 1'b1; phase_next = PH_WR_END;
                                sub_next = SB_DUMMY; pos_next = 10'd1; res.tx_byte = 8'hff;
                            end else begin
                                poll_next = poll_reg + 16'd1;
                                if (poll_next >= cfg.busy_poll_limit) begin
                                    cs_next = 1'b1; phase_next = PH_IDLE; sub_next = SB_NONE;
                                    res.done_res = 1'b1; res.status = ST_BUSY_TO;
                                end else begin
                                    res.tx_byte = 8'hff;
                                end
                            end
                        end
                        default: emit = 1'b0;
                    endcase
                end
                default: ;
            endcase
        end

        res.tx_valid    = !res.done_res;
        res.last        = res.done_res;
        res.chip_select = cs_next;
        res.fast_clock  = fast_next;
        res.card_type   = kind_next;
    end

    // held result awaiting buffer data
    sdspi_out_t hold_reg;

    always_comb begin
        push = 1'b0;
        push_data = res;
        if (wpend_reg) begin
            push = 1'b1;
            push_data = hold_reg;
            push_data.tx_byte = bdata;
        end else if (emit && !use_buf) begin
            push = 1'b1;
        end
        wpend_next = emit && use_buf;
    end

    assign pop       = out_valid && out_ready;
    assign out_valid = (q_cnt_reg != 2'd0);
    assign out_data  = q_reg[qhead_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE; sub_reg <= SB_NONE; kind_reg <= '0; pend_reg <= ST_OK;
            poll_reg <= '0; retry_reg <= '0; ms_reg <= '0; pos_reg <= '0;
            frame_reg <= '0; cs_reg <= 1'b1; fast_reg <= 1'b0; wpend_reg <= 1'b0;
            q_cnt_reg <= '0; qhead_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next; sub_reg <= sub_next; kind_reg <= kind_next;
            pend_reg <= pend_next; poll_reg <= poll_next; retry_reg <= retry_next;
            ms_reg <= ms_next; pos_reg <= pos_next; frame_reg <= frame_next;
            cs_reg <= cs_next; fast_reg <= fast_next; wpend_reg <= wpend_next;
            q_cnt_reg <= q_cnt_reg + {1'b0, push} - {1'b0, pop};
            if (pop) qhead_reg <= !qhead_reg;
        end
    end

    // tail slot sits count entries past the head
    always_ff @(posedge aclk) begin
        if (emit) hold_reg <= res;
        if (push) q_reg[qhead_reg ^ q_cnt_reg[0]] <= push_data;
    end
endmodule

### rtl/core/sd_spi_host_sequencer.sv
// ----------------------------------------------------------------------------
// sd_spi_host_sequencer
// sd card host in spi mode, one spi byte exchange per returned beat
// ----------------------------------------------------------------------------
//  channel   ports                    direction  content
//  request   s_valid s_ready s_data   in         request / rx byte / tick beat
//  result    m_valid m_ready m_data   out        tx request or completion
//  config    cfg_valid cfg_ready ...  in         register index and value
//
// each beat is handled in the cycle it is taken; a write stream byte is read from the
// block buffer ram, whose registered read holds the input until the byte lands.
// results go through a two-entry queue so input is taken while one waits.
// reset (aresetn low, synchronous) returns the sequencer to idle with
// default register values; the buffer contents are kept.
module sd_spi_host_sequencer (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sdspi_pkg::sdspi_in_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sdspi_pkg::sdspi_out_t m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [31:0]           cfg_data
);
    import sdspi_pkg::*;

    sdspi_cfg_t cfg;
    sdspi_brd_t brd;
    logic [7:0] bdata;
    logic       busy;
    logic       load;

    assign cfg_ready = 1'b1;
    assign load = s_valid && s_ready && (s_data.req_type == REQ_LOAD);

    sdspi_cfg u_cfg (
        .aclk(aclk), .aresetn(aresetn), .wr_en(cfg_valid && cfg_ready),
        .wr_index(cfg_index), .wr_data(cfg_data), .cfg(cfg)
    );

    sdspi_buf u_buf (
        .aclk(aclk), .we(load), .waddr(s_data.data_index[BLK_AW-1:0]),
        .wdata(s_data.data_byte), .rd(brd), .rdata(bdata)
    );

    sdspi_seq u_seq (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_valid), .in_ready(s_ready),
        .in_data(s_data), .cfg(cfg), .brd(brd), .bdata(bdata),
        .out_valid(m_valid), .out_ready(m_ready), .out_data(m_data), .busy(busy)
    );

    a_last_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last == m_data.done_res))
        else $error("last and done disagree");
    a_done_tx: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.done_res) |-> !m_data.tx_valid)
        else $error("completion carries an exchange");
    a_idle_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> busy)
        else $error("result queued while idle");
endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the sd spi host sequencer: the bench plays both the
// host and the card, predicts every result beat and compares it field by field
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sdspi_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int RAND_ITEMS  = 1100;
    localparam int SETTLE      = 8;

    typedef enum logic [5:0] {
        P_IDLE, P_PWR, P_DUMMY10, P_PON_CMD0, P_PON_DUMP, P_CMD0, P_CMD8,
        P_V1_DUMP, P_V1_55, P_V1_41, P_V1_FAST, P_CMD59, P_CMD16,
        P_V2_OCR8, P_V2_DUMP, P_V2_55, P_V2_41, P_CMD58, P_V2_OCR58,
        P_FINAL, P_CMD17, P_RD_GAP, P_RD_END, P_CMD24, P_WR_GAP, P_WR_END
    } seq_phase_e;

    typedef enum logic [3:0] {
        X_NONE, X_WAIT_MS, X_DUMMY, X_READY, X_SEND, X_RESP, X_IDLE_RESP,
        X_OCR, X_TOKEN, X_DATA, X_CRC, X_WSTREAM, X_BUSY
    } xfer_e;

    typedef struct {
        sdspi_in_t  it;
        bit         typed;
        bit         has;
        sdspi_out_t res;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    sdspi_in_t   s_data;
    logic        m_valid;
    logic        m_ready;
    sdspi_out_t  m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    sd_spi_host_sequencer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // card sequencer model state
    seq_phase_e ph;
    xfer_e      xs;
    logic [1:0] kind;
    logic [2:0] pend;
    int         polls, retries, ms, pos;
    logic [47:0] frame;
    logic [7:0] blk [BLOCK_BYTES];
    logic       cs, fast;
    int         c_ready, c_pwr, c_idle, c_resp, c_retry, c_token, c_busy;
    sdspi_out_t r;
    bit         got;

    sdspi_out_t beat_q [$];
    row_t       rows [$];
    int         errs = 0;
    int         cyc = 0;
    bit         calm;
    bit         buf_full = 0;
    bit         press_go = 0;
    bit         press_done = 0;

    function automatic void p_tx(logic [7:0] b);
        r = '0;
        r.tx_byte = b;
        r.tx_valid = 1'b1;
        got = 1;
    endfunction

    function automatic void p_finish(logic [2:0] st);
        ph = P_IDLE;
        xs = X_NONE;
        r = '0;
        r.done_res = 1'b1;
        r.status = st;
        r.last = 1'b1;
        got = 1;
    endfunction

    function automatic void p_fail(logic [2:0] st);
        cs = 1'b1;
        p_finish(st);
    endfunction

    function automatic void p_dummy(seq_phase_e step, int n);
        ph = step;
        xs = X_DUMMY;
        pos = n;
        p_tx(8'hFF);
    endfunction

    function automatic logic [7:0] frame_byte(int p);
        return 8'(frame >> ((5 - (p % 6)) * 8));
    endfunction

    function automatic void p_cmd(seq_phase_e step, logic [7:0] cmd, logic [31:0] arg,
                                  logic [7:0] crc);
        ph = step;
        frame = {cmd, arg, crc};
        xs = X_READY;
        ms = 0;
        p_tx(8'hFF);
    endfunction

    function automatic void p_polls(seq_phase_e step, xfer_e s);
        ph = step;
        xs = s;
        pos = 0;
        polls = 0;
        p_tx(8'hFF);
    endfunction

    function automatic void p_final();
        cs = 1'b1;
        p_dummy(P_FINAL, 1);
    endfunction

    function automatic logic [7:0] wr_stream_byte(int p);
        if (p < 3 || p >= BLOCK_BYTES + 4) return 8'hFF;
        if (p == 3) return 8'hFE;
        return blk[(p - 4) % BLOCK_BYTES];
    endfunction

    function automatic void dummy_done();
        case (ph)
            P_DUMMY10: begin
                cs = 1'b0;
                ph = P_PON_CMD0;
                frame = {8'h40, 32'h0, 8'h95};
                xs = X_SEND;
                pos = 0;
                p_tx(frame_byte(0));
            end
            P_PON_DUMP: begin
                if (pend != ST_OK) begin
                    p_finish(pend);
                end else begin
                    cs = 1'b0;
                    p_cmd(P_CMD0, 8'h40, 32'h0, 8'h95);
                end
            end
            P_V1_DUMP: begin
                retries = 0; cs = 1'b0; p_cmd(P_V1_55, 8'h77, 32'h0, 8'h00);
            end
            P_V2_DUMP: begin
                retries = 0; cs = 1'b0; p_cmd(P_V2_55, 8'h77, 32'h0, 8'h00);
            end
            P_V1_FAST: p_cmd(P_CMD59, 8'h7B, 32'h0, 8'h95);
            P_FINAL: begin
                fast = 1'b1; p_finish(ST_OK);
            end
            P_RD_GAP: begin
                cs = 1'b0; p_polls(P_RD_GAP, X_TOKEN);
            end
            P_WR_GAP: begin
                cs = 1'b0; p_polls(P_WR_GAP, X_WSTREAM);
            end
            default: p_finish(ST_OK);
        endcase
    endfunction

    function automatic void cmd_done(logic [7:0] rsp);
        case (ph)
            P_CMD0: begin
                if (rsp == 8'h01) p_cmd(P_CMD8, 8'h48, 32'h1AA, 8'h87);
                else p_fail(ST_NO_RESP);
            end
            P_CMD8: begin
                if (rsp == 8'h05) begin
                    kind = 2'd1; cs = 1'b1; p_dummy(P_V1_DUMP, 1);
                end else if (rsp == 8'h01) begin
                    p_polls(P_V2_OCR8, X_OCR);
                end else begin
                    p_final();
                end
            end
            P_V1_55: p_cmd(P_V1_41, 8'h69, 32'h0, 8'h00);
            P_V2_55: p_cmd(P_V2_41, 8'h69, 32'h40000000, 8'h00);
            P_V1_41, P_V2_41: begin
                if (retries < 511) retries++;
                if (rsp == 8'h00) begin
                    if (ph == P_V1_41) begin
                        fast = 1'b1; p_dummy(P_V1_FAST, 1);
                    end else begin
                        p_cmd(P_CMD58, 8'h7A, 32'h0, 8'h00);
                    end
                end else if (retries >= c_retry) begin
                    p_fail(ST_RETRY);
                end else begin
                    p_cmd(ph == P_V1_41 ? P_V1_55 : P_V2_55, 8'h77, 32'h0, 8'h00);
                end
            end
            P_CMD59: p_cmd(P_CMD16, 8'h50, BLOCK_BYTES, 8'h95);
            P_CMD16: p_final();
            P_CMD58: begin
                if (rsp != 8'h00) p_fail(ST_NO_RESP);
                else p_polls(P_V2_OCR58, X_OCR);
            end
            P_CMD17: begin
                if (rsp != 8'h00) begin
                    p_fail(ST_NO_RESP);
                end else begin
                    cs = 1'b1; p_dummy(P_RD_GAP, 1);
                end
            end
            P_CMD24: begin
                if (rsp != 8'h00) begin
                    p_fail(ST_NO_RESP);
                end else begin
                    cs = 1'b1; p_dummy(P_WR_GAP, 1);
                end
            end
            default: p_fail(ST_NO_RESP);
        endcase
    endfunction

    function automatic void card_byte_in(logic [7:0] rx);
        case (xs)
            X_DUMMY: begin
                if (pos > 0) pos--;
                if (pos == 0) dummy_done(); else p_tx(8'hFF);
            end
            X_READY: begin
                if (rx == 8'hFF) begin
                    xs = X_SEND; pos = 0; p_tx(frame_byte(0));
                end else if (ms >= c_ready) begin
                    p_fail(ST_READY_TO);
                end else begin
                    p_tx(8'hFF);
                end
            end
            X_SEND: begin
                pos++;
                if (pos < 6) begin
                    p_tx(frame_byte(pos));
                end else begin
                    xs = (ph == P_PON_CMD0) ? X_IDLE_RESP : X_RESP;
                    polls = 0;
                    p_tx(8'hFF);
                end
            end
            X_RESP: begin
                if (rx != 8'hFF) cmd_done(rx);
                else if (polls > c_resp) p_fail(ST_NO_RESP);
                else begin
                    polls++; p_tx(8'hFF);
                end
            end
            X_IDLE_RESP: begin
                if (rx == 8'h01 || polls >= c_idle) begin
                    pend = (rx == 8'h01) ? ST_OK : ST_NO_RESP;
                    cs = 1'b1;
                    p_dummy(P_PON_DUMP, 1);
                end else begin
                    polls++; p_tx(8'hFF);
                end
            end
            X_OCR: begin
                if (ph == P_V2_OCR58 && pos == 0) kind = rx[6] ? 2'd3 : 2'd2;
                pos++;
                if (pos < 4) p_tx(8'hFF);
                else if (ph == P_V2_OCR8) begin
                    cs = 1'b1; p_dummy(P_V2_DUMP, 1);
                end else p_final();
            end
            X_TOKEN: begin
                if (rx == 8'hFE) begin
                    xs = X_DATA; pos = 0; p_tx(8'hFF);
                end else if (polls >= c_token) begin
                    p_fail(ST_TOKEN_TO);
                end else begin
                    polls++; p_tx(8'hFF);
                end
            end
            X_DATA: begin
                p_tx(8'hFF);
                r.read_byte = rx;
                r.read_valid = 1'b1;
                r.read_index = pos % BLOCK_BYTES;
                pos++;
                if (pos >= BLOCK_BYTES) begin
                    xs = X_CRC; pos = 0;
                end
            end
            X_CRC: begin
                pos++;
                if (pos < 2) p_tx(8'hFF);
                else begin
                    cs = 1'b1; p_dummy(P_RD_END, 1);
                end
            end
            X_WSTREAM: begin
                if (pos >= WSTREAM_LAST) begin
                    if (rx[4:0] != 5'h05) p_fail(ST_WR_REJ);
                    else begin
                        xs = X_BUSY; polls = 0; p_tx(8'hFF);
                    end
                end else begin
                    pos++; p_tx(wr_stream_byte(pos));
                end
            end
            X_BUSY: begin
                if (rx != 8'h00) begin
                    cs = 1'b1; p_dummy(P_WR_END, 1);
                end else begin
                    polls++;
                    if (polls >= c_busy) p_fail(ST_BUSY_TO); else p_tx(8'hFF);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void predict_beat(sdspi_in_t it);
        logic [31:0] addr;
        addr = (kind == 2'd3) ? it.sector : {it.sector[22:0], 9'd0};
        got = 0;
        case (it.req_type)
            REQ_INIT: begin
                if (ph == P_IDLE) begin
                    kind = 2'd0; cs = 1'b1; fast = 1'b0; ms = 0;
                    if (c_pwr == 0) p_dummy(P_DUMMY10, 10);
                    else begin
                        ph = P_PWR; xs = X_WAIT_MS;
                    end
                end
            end
            REQ_READ: begin
                if (ph == P_IDLE) begin
                    cs = 1'b0; p_cmd(P_CMD17, 8'h51, addr, 8'h00);
                end
            end
            REQ_WRITE: begin
                if (ph == P_IDLE) begin
                    cs = 1'b0; p_cmd(P_CMD24, 8'h58, addr, 8'h00);
                end
            end
            REQ_LOAD: blk[it.data_index] = it.data_byte;
            REQ_RX: if (ph != P_IDLE) card_byte_in(it.rx_byte);
            REQ_TICK: begin
                if (xs == X_WAIT_MS || xs == X_READY) begin
                    if (ms < 1023) ms++;
                    if (xs == X_WAIT_MS && ms >= c_pwr) p_dummy(P_DUMMY10, 10);
                end
            end
            default: ;
        endcase
        if (got) begin
            r.chip_select = cs;
            r.fast_clock = fast;
            r.card_type = kind;
        end
    endfunction

    function automatic sdspi_in_t mk_item(logic [2:0] req, logic [31:0] sec,
                                          logic [7:0] rx, logic [7:0] d, logic [8:0] idx);
        sdspi_in_t it;
        it.req_type = req;
        it.sector = sec;
        it.rx_byte = rx;
        it.data_byte = d;
        it.data_index = idx;
        return it;
    endfunction

    function automatic sdspi_out_t mk_tx(logic [7:0] b, logic c);
        sdspi_out_t o;
        o = '0;
        o.tx_byte = b;
        o.tx_valid = 1'b1;
        o.chip_select = c;
        return o;
    endfunction

    function automatic sdspi_out_t mk_done(logic [2:0] st);
        sdspi_out_t o;
        o = '0;
        o.done_res = 1'b1;
        o.status = st;
        o.last = 1'b1;
        o.chip_select = 1'b1;
        return o;
    endfunction

    function automatic void add_row(sdspi_in_t it, bit typed, bit has, sdspi_out_t res);
        row_t rw;
        rw.it = it;
        rw.typed = typed;
        rw.has = has;
        rw.res = res;
        rows.push_back(rw);
    endfunction

    // what a plausible card answers, given where the sequencer stands
    function automatic logic [7:0] card_reply();
        int n;
        n = $urandom_range(99);
        case (xs)
            X_READY: return (n < 80) ? 8'hFF : 8'($urandom_range(254));
            X_RESP: begin
                if (n < 20) return 8'hFF;
                n = $urandom_range(99);
                case (ph)
                    P_CMD0: return (n < 85) ? 8'h01 : 8'($urandom);
                    P_CMD8: return (n < 45) ? 8'h01 : (n < 85) ? 8'h05 : 8'($urandom);
                    P_V1_41, P_V2_41: return (n < 55) ? 8'h00 : 8'h01;
                    P_CMD58, P_CMD17, P_CMD24: return (n < 85) ? 8'h00 : 8'($urandom);
                    default: return (n < 60) ? 8'h01 : 8'h00;
                endcase
            end
            X_IDLE_RESP: return (n < 60) ? 8'h01 : 8'hFF;
            X_TOKEN: return (n < 40) ? 8'hFE : 8'hFF;
            X_WSTREAM: begin
                if (pos >= WSTREAM_LAST && n < 80) return {3'($urandom), 5'h05};
                return 8'($urandom);
            end
            X_BUSY: return (n < 65) ? 8'h00 : 8'($urandom);
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic sdspi_in_t next_item();
        sdspi_in_t it;
        int n;
        it = mk_item(3'($urandom), $urandom, 8'($urandom), 8'($urandom), 9'($urandom));
        n = $urandom_range(99);
        if (ph == P_IDLE) begin
            if (n < 8) it.req_type = 3'($urandom);
            else if (n < 45) it.req_type = REQ_INIT;
            else if (n < 75 || !buf_full) it.req_type = REQ_READ;
            else it.req_type = REQ_WRITE;
            // never stream a block that was not fully loaded
            if (it.req_type == REQ_WRITE && !buf_full) it.req_type = REQ_LOAD;
        end else if (xs == X_WAIT_MS) begin
            if (n < 85) it.req_type = REQ_TICK;
        end else if (n >= 8) begin
            if (xs == X_READY && n < 20) begin
                it.req_type = REQ_TICK;
            end else begin
                it.req_type = REQ_RX;
                it.rx_byte = card_reply();
            end
        end
        return it;
    endfunction

    function automatic int pick_gap();
        int n;
        n = $urandom_range(99);
        if (calm || n < 60) return 0;
        if (n < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_beat(sdspi_in_t it, bit typed, bit has, sdspi_out_t res);
        int g;
        predict_beat(it);
        if (typed) begin
            if (has) beat_q.push_back(res);
        end else if (got) begin
            beat_q.push_back(r);
        end
        s_data <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        g = pick_gap();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic cfg_write(logic [2:0] idx, int val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_READY_TO:  c_ready = val & 32'h3FF;
            CFG_PWR_DLY:   c_pwr = val & 32'h3FF;
            CFG_IDLE_LIM:  c_idle = val & 32'hFFFF;
            CFG_RESP_LIM:  c_resp = val & 32'hFF;
            CFG_RETRY_LIM: c_retry = val & 32'h1FF;
            CFG_TOKEN_LIM: c_token = val & 32'hFFFF;
            CFG_BUSY_LIM:  c_busy = val & 32'hFFFF;
            default: ;
        endcase
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (beat_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_all(int a, int b, int c, int d, int e, int f, int g);
        settle();
        cfg_write(CFG_READY_TO, a);
        cfg_write(CFG_PWR_DLY, b);
        cfg_write(CFG_IDLE_LIM, c);
        cfg_write(CFG_RESP_LIM, d);
        cfg_write(CFG_RETRY_LIM, e);
        cfg_write(CFG_TOKEN_LIM, f);
        cfg_write(CFG_BUSY_LIM, g);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(int n);
        int cnt;
        sdspi_in_t it;
        cnt = 0;
        while (!(cnt >= n && ph == P_IDLE)) begin
            it = next_item();
            send_beat(it, 0, 0, '0);
            cnt++;
        end
    endtask

    task automatic check_beat(sdspi_out_t e, sdspi_out_t a);
        if (a.tx_byte !== e.tx_byte) begin
            $error("tx_byte expected %0h got %0h", e.tx_byte, a.tx_byte); errs++;
        end
        if (a.tx_valid !== e.tx_valid) begin
            $error("tx_valid expected %0h got %0h", e.tx_valid, a.tx_valid); errs++;
        end
        if (a.chip_select !== e.chip_select) begin
            $error("chip_select expected %0h got %0h", e.chip_select, a.chip_select); errs++;
        end
        if (a.fast_clock !== e.fast_clock) begin
            $error("fast_clock expected %0h got %0h", e.fast_clock, a.fast_clock); errs++;
        end
        if (a.read_byte !== e.read_byte) begin
            $error("read_byte expected %0h got %0h", e.read_byte, a.read_byte); errs++;
        end
        if (a.read_valid !== e.read_valid) begin
            $error("read_valid expected %0h got %0h", e.read_valid, a.read_valid); errs++;
        end
        if (a.read_index !== e.read_index) begin
            $error("read_index expected %0h got %0h", e.read_index, a.read_index); errs++;
        end
        if (a.done_res !== e.done_res) begin
            $error("done_res expected %0h got %0h", e.done_res, a.done_res); errs++;
        end
        if (a.status !== e.status) begin
            $error("status expected %0h got %0h", e.status, a.status); errs++;
        end
        if (a.card_type !== e.card_type) begin
            $error("card_type expected %0h got %0h", e.card_type, a.card_type); errs++;
        end
        if (a.last !== e.last) begin
            $error("last expected %0h got %0h", e.last, a.last); errs++;
        end
    endtask

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cyc <= cyc + 1;
        calm <= ((cyc / 1500) % 4) == 0;
        if (cyc > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: check each beat, then pick the next ready level
    int stall = 0;
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (beat_q.size() == 0) begin
                $error("result beat with nothing expected");
                errs++;
            end else begin
                check_beat(beat_q.pop_front(), m_data);
            end
        end
        if (press_go && !press_done) begin
            press_done = 1;
            stall = 400;
        end
        if (stall > 0) begin
            stall--;
            m_ready <= 1'b0;
        end else if (calm) begin
            m_ready <= 1'b1;
        end else begin
            if ($urandom_range(99) < 10)
                stall = ($urandom_range(9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
            m_ready <= (stall == 0);
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        ph = P_IDLE; xs = X_NONE; kind = 2'd0; pend = ST_OK;
        polls = 0; retries = 0; ms = 0; pos = 0; frame = '0;
        cs = 1'b1; fast = 1'b0;
        c_ready = 500; c_pwr = 100; c_idle = 8191; c_resp = 200;
        c_retry = 400; c_token = 4095; c_busy = 65534;

        // stray beats, unknown codes, buffer loads at both ends
        add_row(mk_item(REQ_RX, 0, 8'hFF, 0, 0), 1, 0, '0);
        add_row(mk_item(REQ_TICK, 0, 0, 0, 0), 1, 0, '0);
        add_row(mk_item(3'd6, 32'hFFFFFFFF, 8'hFF, 8'hFF, 9'h1FF), 1, 0, '0);
        add_row(mk_item(3'd7, 0, 0, 0, 0), 1, 0, '0);
        add_row(mk_item(REQ_LOAD, 0, 0, 8'hFF, 9'h1FF), 1, 0, '0);
        add_row(mk_item(REQ_LOAD, 0, 0, 8'h00, 9'h000), 1, 0, '0);
        // read of the top sector: address wraps, answer is rejected
        add_row(mk_item(REQ_READ, 32'hFFFFFFFF, 0, 0, 0), 1, 1, mk_tx(8'hFF, 1'b0));
        add_row(mk_item(REQ_RX, 0, 8'h00, 0, 0), 1, 1, mk_tx(8'hFF, 1'b0));
        add_row(mk_item(REQ_TICK, 0, 0, 0, 0), 1, 0, '0);
        add_row(mk_item(REQ_RX, 0, 8'hFF, 0, 0), 1, 1, mk_tx(8'h51, 1'b0));
        add_row(mk_item(REQ_RX, 0, 8'hFF, 0, 0), 1, 1, mk_tx(8'hFF, 1'b0));
        add_row(mk_item(REQ_RX, 0, 8'hFF, 0, 0), 1, 1, mk_tx(8'hFF, 1'b0));
        add_row(mk_item(REQ_RX, 0, 8'hFF, 0, 0), 1, 1, mk_tx(8'hFE, 1'b0));
        add_row(mk_item(REQ_RX, 0, 8'hFF, 0, 0), 1, 1, mk_tx(8'h00, 1'b0));
        add_row(mk_item(REQ_RX, 0, 8'hFF, 0, 0), 1, 1, mk_tx(8'h00, 1'b0));
        add_row(mk_item(REQ_RX, 0, 8'hFF, 0, 0), 1, 1, mk_tx(8'hFF, 1'b0));
        add_row(mk_item(REQ_INIT, 0, 0, 0, 0), 1, 0, '0);
        add_row(mk_item(REQ_RX, 0, 8'hFF, 0, 0), 1, 1, mk_tx(8'hFF, 1'b0));
        add_row(mk_item(REQ_RX, 0, 8'h04, 0, 0), 1, 1, mk_done(ST_NO_RESP));
        // write of sector zero, command answered with idle
        add_row(mk_item(REQ_WRITE, 0, 0, 0, 0), 0, 0, '0);
        for (int i = 0; i < 7; i++) add_row(mk_item(REQ_RX, 0, 8'hFF, 0, 0), 0, 0, '0);
        add_row(mk_item(REQ_RX, 0, 8'h01, 0, 0), 1, 1, mk_done(ST_NO_RESP));

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) send_beat(rows[i].it, rows[i].typed, rows[i].has, rows[i].res);

        set_all($urandom_range(1, 4), $urandom_range(0, 3), $urandom_range(1, 6),
                $urandom_range(1, 4), $urandom_range(1, 6), $urandom_range(1, 10),
                $urandom_range(1, 10));
        for (int i = 0; i < BLOCK_BYTES; i++)
            send_beat(mk_item(REQ_LOAD, $urandom, 8'($urandom), 8'($urandom), 9'(i)),
                      0, 0, '0);
        buf_full = 1;
        press_go = 1;
        run_random(RAND_ITEMS / 5);

        set_all(1, 0, 1, 1, 1, 1, 1);
        run_random(RAND_ITEMS / 5);

        // zero limits fail on the first unmatched poll, but the response poll fails on the second
        set_all(0, 0, 0, 0, 0, 0, 0);
        run_random(RAND_ITEMS / 5);

        set_all(1023, 6, 65535, 255, 511, 65535, 65535);
        run_random(RAND_ITEMS / 5);

        set_all($urandom_range(1, 8), $urandom_range(0, 5), $urandom_range(1, 20),
                $urandom_range(1, 8), $urandom_range(1, 12), $urandom_range(1, 30),
                $urandom_range(1, 30));
        run_random(RAND_ITEMS / 5);

        settle();
        repeat (20) @(posedge aclk);
        if (errs == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
